@@ hdl/wsp_pkg.sv @@
// ----------------------------------------------------------------------------
// wsp_pkg
// Constants, types and the divider step shared by the projection pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

  localparam int FRAC_BITS = 16;

  localparam int CRD_W = 32;                 // coordinates, elements, results
  localparam int SCR_W = 13;                 // viewport size registers
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 64;

  localparam int PRD_W = 2 * CRD_W;          // exact element * coordinate
  localparam int PS_W = PRD_W - FRAC_BITS;   // product floored to F fraction bits
  localparam int DOT_W = PS_W + 2;           // sum of three products and a constant
  localparam int MS_W = DOT_W + SCR_W;       // magnitude times viewport size
  localparam int D_W = MS_W + FRAC_BITS;     // dividend
  localparam int DEN_W = DOT_W + 1;          // 2 * w
  localparam int QB = 40;                    // quotient magnitude cap is 2^QB
  localparam int CW = DEN_W + QB;            // compare width in the divider
  localparam int RES_W = QB + 3;

  localparam int STEP = 2;                   // quotient bits per divider stage
  localparam int NDIV = QB / STEP;

  localparam int NEAR_LIM = ((1 << FRAC_BITS) + 50) / 100;

  localparam logic [CFG_IDX_W-1:0] IDX_ROW_X_LO = 4'd0;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW_X_HI = 4'd1;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW_Y_LO = 4'd2;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW_Y_HI = 4'd3;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW_W_LO = 4'd4;
  localparam logic [CFG_IDX_W-1:0] IDX_ROW_W_HI = 4'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_SCR_W = 4'd6;
  localparam logic [CFG_IDX_W-1:0] IDX_SCR_H = 4'd7;

  localparam logic [SCR_W-1:0] SCR_W_RESET = 13'd1920;
  localparam logic [SCR_W-1:0] SCR_H_RESET = 13'd1080;

  typedef struct packed {
    logic ok;
    logic neg_x;
    logic neg_y;
    logic sat_x;
    logic sat_y;
    logic [DEN_W-1:0] den;
    logic [D_W-1:0] rem_x;
    logic [D_W-1:0] rem_y;
    logic [QB-1:0] q_x;
    logic [QB-1:0] q_y;
  } div_t;

  // restoring division, STEP quotient bits starting at bit top
  function automatic div_t div_step(div_t s, int top);
    div_t r;
    logic [CW-1:0] dsh;
    logic [CW-1:0] rx;
    logic [CW-1:0] ry;
    r = s;
    for (int j = 0; j < STEP; j++) begin
      dsh = CW'(r.den) << (top - j);
      rx = CW'(r.rem_x);
      ry = CW'(r.rem_y);
      if (rx >= dsh) begin
        r.rem_x = D_W'(rx - dsh);
        r.q_x[top-j] = 1'b1;
      end
      if (ry >= dsh) begin
        r.rem_y = D_W'(ry - dsh);
        r.q_y[top-j] = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ hdl/world_to_screen_projection.sv @@
// ----------------------------------------------------------------------------
// world_to_screen_projection
// Perspective projection of a world point through a view-projection matrix
// and viewport transform to screen pixels.
// ----------------------------------------------------------------------------
// usage:
//   input words (pos_x, pos_y, pos_z) enter on in_valid/in_stall; one result
//   word (visible, screen_x, screen_y) leaves on out_valid/out_stall for each.
//   matrix rows and viewport size are written on the cfg channel (cfg_ready
//   is always high); write only while no word is in flight (not enforced).
//   from accept to out_valid a word passes products, row sums, magnitude,
//   viewport scaling, divider setup, 20 divider stages of two quotient bits
//   each for both coordinates, sign fix-up and the output add, all registered;
//   the pipelined divider sets the depth; one word per cycle unless stalled.
//   while the output word is stalled the whole pipeline holds and in_stall
//   is high; nothing is dropped or repeated.
//   reset empties the pipeline, clears the matrix and sets the viewport to
//   1920 by 1080.
// ----------------------------------------------------------------------------
`default_nettype none

module world_to_screen_projection (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [wsp_pkg::CRD_W-1:0]      pos_x,
  input  wire logic signed [wsp_pkg::CRD_W-1:0]      pos_y,
  input  wire logic signed [wsp_pkg::CRD_W-1:0]      pos_z,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       visible,
  output logic signed [wsp_pkg::CRD_W-1:0]           screen_x,
  output logic signed [wsp_pkg::CRD_W-1:0]           screen_y,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [wsp_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [wsp_pkg::CFG_DATA_W-1:0]        cfg_data
);

  localparam int CRD_W = wsp_pkg::CRD_W;
  localparam int PRD_W = wsp_pkg::PRD_W;
  localparam int PS_W = wsp_pkg::PS_W;
  localparam int DOT_W = wsp_pkg::DOT_W;
  localparam int MS_W = wsp_pkg::MS_W;
  localparam int D_W = wsp_pkg::D_W;
  localparam int DEN_W = wsp_pkg::DEN_W;
  localparam int QB = wsp_pkg::QB;
  localparam int RES_W = wsp_pkg::RES_W;
  localparam int NDIV = wsp_pkg::NDIV;
  localparam int STEP = wsp_pkg::STEP;
  localparam int F = wsp_pkg::FRAC_BITS;
  localparam int SCR_W = wsp_pkg::SCR_W;

  // configuration
  logic [wsp_pkg::CFG_DATA_W-1:0] row_x_lo, row_x_hi, row_y_lo, row_y_hi, row_w_lo, row_w_hi;
  logic [SCR_W-1:0] scr_w, scr_h;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_x_lo <= '0;
      row_x_hi <= '0;
      row_y_lo <= '0;
      row_y_hi <= '0;
      row_w_lo <= '0;
      row_w_hi <= '0;
      scr_w <= wsp_pkg::SCR_W_RESET;
      scr_h <= wsp_pkg::SCR_H_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        wsp_pkg::IDX_ROW_X_LO: row_x_lo <= cfg_data;
        wsp_pkg::IDX_ROW_X_HI: row_x_hi <= cfg_data;
        wsp_pkg::IDX_ROW_Y_LO: row_y_lo <= cfg_data;
        wsp_pkg::IDX_ROW_Y_HI: row_y_hi <= cfg_data;
        wsp_pkg::IDX_ROW_W_LO: row_w_lo <= cfg_data;
        wsp_pkg::IDX_ROW_W_HI: row_w_hi <= cfg_data;
        wsp_pkg::IDX_SCR_W:    scr_w <= cfg_data[SCR_W-1:0];
        wsp_pkg::IDX_SCR_H:    scr_h <= cfg_data[SCR_W-1:0];
        default: ;
      endcase
    end
  end

  // global advance: the pipeline moves unless the output word is held
  logic adv;
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;

  logic signed [CRD_W-1:0] e0, e1, e2, e3, e4, e5, e6, e7, e12, e13, e14, e15;
  assign e0 = signed'(row_x_lo[CRD_W-1:0]);
  assign e1 = signed'(row_x_lo[2*CRD_W-1:CRD_W]);
  assign e2 = signed'(row_x_hi[CRD_W-1:0]);
  assign e3 = signed'(row_x_hi[2*CRD_W-1:CRD_W]);
  assign e4 = signed'(row_y_lo[CRD_W-1:0]);
  assign e5 = signed'(row_y_lo[2*CRD_W-1:CRD_W]);
  assign e6 = signed'(row_y_hi[CRD_W-1:0]);
  assign e7 = signed'(row_y_hi[2*CRD_W-1:CRD_W]);
  assign e12 = signed'(row_w_lo[CRD_W-1:0]);
  assign e13 = signed'(row_w_lo[2*CRD_W-1:CRD_W]);
  assign e14 = signed'(row_w_hi[CRD_W-1:0]);
  assign e15 = signed'(row_w_hi[2*CRD_W-1:CRD_W]);

  // stage 1: products
  logic v1, zero1;
  logic signed [PRD_W-1:0] p0, p1, p2, p4, p5, p6, p12, p13, p14;
  // stage 2: row sums
  logic v2, zero2;
  logic signed [DOT_W-1:0] cx2, cy2, w2;
  // stage 3: magnitudes and divisor
  logic v3;
  logic ok3, neg_x3, neg_y3;
  logic [DOT_W-1:0] mag_x3, mag_y3;
  logic [DEN_W-1:0] den3;
  // stage 4: scaled by viewport size
  logic v4;
  logic ok4, neg_x4, neg_y4;
  logic [MS_W-1:0] ms_x4, ms_y4;
  logic [DEN_W-1:0] den4;
  // divider stages
  logic [NDIV:0] dv;
  wsp_pkg::div_t ds [NDIV+1];
  // sign fix-up
  logic v_f;
  logic ok_f;
  logic signed [RES_W-1:0] res_x, res_y;

  logic signed [PS_W-1:0] f0, f1, f2, f4, f5, f6, f12, f13, f14;
  assign f0 = PS_W'(p0 >>> F);
  assign f1 = PS_W'(p1 >>> F);
  assign f2 = PS_W'(p2 >>> F);
  assign f4 = PS_W'(p4 >>> F);
  assign f5 = PS_W'(p5 >>> F);
  assign f6 = PS_W'(p6 >>> F);
  assign f12 = PS_W'(p12 >>> F);
  assign f13 = PS_W'(p13 >>> F);
  assign f14 = PS_W'(p14 >>> F);

  logic [D_W-1:0] dvd_x, dvd_y;
  logic [DEN_W+QB-1:0] lim4;
  assign dvd_x = D_W'(ms_x4) << F;
  assign dvd_y = D_W'(ms_y4) << F;
  assign lim4 = (DEN_W+QB)'(den4) << QB;

  logic signed [RES_W-1:0] cap;
  assign cap = RES_W'(1) <<< QB;

  function automatic logic signed [RES_W-1:0] fix_sign(logic neg, logic sat,
                                                      logic [QB-1:0] q,
                                                      logic [D_W-1:0] rem,
                                                      logic signed [RES_W-1:0] lim);
    logic signed [RES_W-1:0] qs;
    qs = signed'(RES_W'(q));
    if (sat) return neg ? -lim : lim;
    if (neg) return -qs - RES_W'(rem != '0);
    return qs;
  endfunction

  logic signed [RES_W-1:0] base_x, base_y, sum_x, sum_y;
  assign base_x = (signed'(RES_W'(scr_w)) + RES_W'(1)) <<< (F - 1);
  assign base_y = (signed'(RES_W'(scr_h)) - RES_W'(1)) <<< (F - 1);
  assign sum_x = base_x + res_x;
  assign sum_y = base_y + res_y;

  function automatic logic signed [CRD_W-1:0] sat32(logic signed [RES_W-1:0] v);
    logic signed [RES_W-1:0] hi, lo;
    hi = signed'(RES_W'({1'b0, {(CRD_W-1){1'b1}}}));
    lo = -hi - RES_W'(1);
    if (v > hi) return hi[CRD_W-1:0];
    if (v < lo) return lo[CRD_W-1:0];
    return v[CRD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      dv <= '0;
      v_f <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      dv <= {dv[NDIV-1:0], v4};
      v_f <= dv[NDIV];
      out_valid <= v_f;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      zero1 <= (e0 == '0);
      p0 <= PRD_W'(e0) * PRD_W'(pos_x);
      p1 <= PRD_W'(e1) * PRD_W'(pos_y);
      p2 <= PRD_W'(e2) * PRD_W'(pos_z);
      p4 <= PRD_W'(e4) * PRD_W'(pos_x);
      p5 <= PRD_W'(e5) * PRD_W'(pos_y);
      p6 <= PRD_W'(e6) * PRD_W'(pos_z);
      p12 <= PRD_W'(e12) * PRD_W'(pos_x);
      p13 <= PRD_W'(e13) * PRD_W'(pos_y);
      p14 <= PRD_W'(e14) * PRD_W'(pos_z);

      zero2 <= zero1;
      cx2 <= DOT_W'(f0) + DOT_W'(f1) + DOT_W'(f2) + DOT_W'(e3);
      cy2 <= DOT_W'(f4) + DOT_W'(f5) + DOT_W'(f6) + DOT_W'(e7);
      w2 <= DOT_W'(f12) + DOT_W'(f13) + DOT_W'(f14) + DOT_W'(e15);

      ok3 <= !zero2 && (w2 >= signed'(DOT_W'(wsp_pkg::NEAR_LIM)));
      neg_x3 <= cx2 < 0;
      mag_x3 <= (cx2 < 0) ? DOT_W'(-cx2) : DOT_W'(cx2);
      neg_y3 <= cy2 > 0;
      mag_y3 <= (cy2 < 0) ? DOT_W'(-cy2) : DOT_W'(cy2);
      den3 <= DEN_W'(unsigned'(w2)) << 1;

      ok4 <= ok3;
      neg_x4 <= neg_x3;
      neg_y4 <= neg_y3;
      ms_x4 <= MS_W'(mag_x3) * MS_W'(scr_w);
      ms_y4 <= MS_W'(mag_y3) * MS_W'(scr_h);
      den4 <= den3;

      // quotient at or above the cap saturates
      ds[0].ok <= ok4;
      ds[0].neg_x <= neg_x4;
      ds[0].neg_y <= neg_y4;
      ds[0].sat_x <= (DEN_W+QB)'(dvd_x) >= lim4;
      ds[0].sat_y <= (DEN_W+QB)'(dvd_y) >= lim4;
      ds[0].den <= den4;
      ds[0].rem_x <= dvd_x;
      ds[0].rem_y <= dvd_y;
      ds[0].q_x <= '0;
      ds[0].q_y <= '0;

      ok_f <= ds[NDIV].ok;
      res_x <= fix_sign(ds[NDIV].neg_x, ds[NDIV].sat_x, ds[NDIV].q_x, ds[NDIV].rem_x, cap);
      res_y <= fix_sign(ds[NDIV].neg_y, ds[NDIV].sat_y, ds[NDIV].q_y, ds[NDIV].rem_y, cap);

      visible <= ok_f;
      screen_x <= ok_f ? sat32(sum_x) : '0;
      screen_y <= ok_f ? sat32(sum_y) : '0;
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    always_ff @(posedge clk) begin
      if (adv) begin
        ds[k+1] <= wsp_pkg::div_step(ds[k], QB - 1 - k * STEP);
      end
    end
  end

  // hidden point reports a zero position
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !visible |-> screen_x == '0 && screen_y == '0)
    else $error("hidden point with nonzero position");

  // the pipeline holds exactly while the output word is held
  assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall out of step with output");

  // a held pipeline keeps its sign fix-up stage word
  assert property (@(posedge clk) disable iff (rst)
    in_stall |=> $stable(v_f) && $stable(res_x) && $stable(res_y))
    else $error("pipeline moved while stalled");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

`default_nettype wire
